// ----- rtl/csvf_pkg.sv -----
// Shared constants, types and codes for the cascaded state-variable filter.
`timescale 1ns / 1ps
package csvf_pkg;

  // Default field widths
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int STATE_BITS_DEF  = 32;

  // Coefficient format, Q4.20
  localparam int COEF_BITS = 24;
  localparam int COEF_FRAC = 20;
  localparam int RND_POS   = COEF_FRAC - 1;

  // Configuration register file
  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = 3;

  // Soft saturator: |s| with 8 fraction bits, clamped to 21 bits
  localparam int SAT_FRAC = 8;
  localparam int U_W      = 21;
  localparam int SQ_W     = 2 * U_W;
  localparam int DIV_W    = 46;
  localparam int QUO_W    = 21;
  localparam logic [U_W-1:0]   U_MAX    = {U_W{1'b1}};
  localparam logic [DIV_W-1:0] SAT_BIAS = DIV_W'(2700) << 16;

  typedef logic signed [COEF_BITS-1:0] coef_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HP_A1      = 3'd0,
    REG_HP_A2      = 3'd1,
    REG_HP_A3      = 3'd2,
    REG_HP_DAMPING = 3'd3,
    REG_LP_A1      = 3'd4,
    REG_LP_A2      = 3'd5,
    REG_LP_A3      = 3'd6,
    REG_LP_DAMPING = 3'd7
  } cfg_reg_e;

  // Coefficient slot within one stage's group of four
  typedef enum logic [1:0] {
    CSEL_A1   = 2'd0,
    CSEL_A2   = 2'd1,
    CSEL_A3   = 2'd2,
    CSEL_DAMP = 2'd3
  } csel_e;

  localparam coef_t COEF_ONE  = 24'sd1048576;
  localparam coef_t COEF_TWO  = 24'sd2097152;
  localparam coef_t COEF_ZERO = 24'sd0;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ,
    S_DIV,
    S_SAT,
    S_A1T,
    S_A2V3,
    S_A2T,
    S_A3V3,
    S_KV1,
    S_OUT
  } seq_state_e;

endpackage

// ----- rtl/cascaded_svf_highpass_lowpass.sv -----
// Cascaded highpass/lowpass trapezoidal state-variable filter, top level.
// One shared bit-serial multiplier (13 products per sample) and a bit-serial divider
//   (2 divisions per sample) do all the arithmetic, so one sample is processed at a time.
// Input stall stays high from acceptance until the result is handed to the output register.
// Reset clears the integrators, loads default coefficients and empties the output.
`timescale 1ns / 1ps
module cascaded_svf_highpass_lowpass import csvf_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int STATE_BITS  = STATE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [SAMPLE_BITS-1:0] sample_in_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [SAMPLE_BITS-1:0] sample_out_o,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [COEF_BITS-1:0]   cfg_data_i
);

  localparam int SB = STATE_BITS;
  localparam int SW = SAMPLE_BITS;
  localparam int WW = ((SB > SW) ? SB : SW) + 4;
  localparam int PW = SB + COEF_BITS;
  localparam int SH = SW - 1 - SAT_FRAC;

  localparam logic signed [WW-1:0] SB_HI = $signed({{(WW-SB+1){1'b0}}, {(SB-1){1'b1}}});
  localparam logic signed [WW-1:0] SB_LO = $signed({{(WW-SB+1){1'b1}}, {(SB-1){1'b0}}});
  localparam logic signed [WW-1:0] SW_HI = $signed({{(WW-SW+1){1'b0}}, {(SW-1){1'b1}}});
  localparam logic signed [WW-1:0] SW_LO = $signed({{(WW-SW+1){1'b1}}, {(SW-1){1'b0}}});

  function automatic logic [SB-1:0] sat_sb(input logic signed [WW-1:0] v);
    logic [SB-1:0] r;
    if (v > SB_HI)      r = SB_HI[SB-1:0];
    else if (v < SB_LO) r = SB_LO[SB-1:0];
    else                r = v[SB-1:0];
    return r;
  endfunction

  function automatic logic [SW-1:0] sat_sw(input logic signed [WW-1:0] v);
    logic [SW-1:0] r;
    if (v > SW_HI)      r = SW_HI[SW-1:0];
    else if (v < SW_LO) r = SW_LO[SW-1:0];
    else                r = v[SW-1:0];
    return r;
  endfunction

  function automatic logic signed [WW-1:0] sx_sb(input logic [SB-1:0] v);
    return $signed({{(WW-SB){v[SB-1]}}, v});
  endfunction

  function automatic logic signed [WW-1:0] sx_sw(input logic [SW-1:0] v);
    return $signed({{(WW-SW){v[SW-1]}}, v});
  endfunction

  seq_state_e state_q, state_d;
  logic       op_run_q, op_run_d;
  logic       stage_q, stage_d;
  logic       out_valid_q, out_valid_d;
  logic       out_load;
  logic       in_acc;

  coef_t         cfg_q [NUM_REGS];
  logic [SB-1:0] hp_i1_q, hp_i2_q, lp_i1_q, lp_i2_q;

  // Datapath registers
  logic [SW-1:0]    x_q;
  logic [SB-1:0]    t_q, v3_q, v1_q, v2_q, pa_q;
  logic [SB-1:0]    mag_q;
  logic             neg_q, pneg_q;
  logic [SQ_W-1:0]  sq_q;
  logic [QUO_W-1:0] r_q;
  logic [SW-1:0]    out_q;

  // Current stage operands
  logic [SB-1:0]    c1, c2, c1_mag, c1_sh;
  logic [U_W-1:0]   u;
  csel_e            csel;
  coef_t            cf;
  logic [COEF_BITS-1:0] cf_mag;
  logic [SB-1:0]    val, val_mag, t_abs;
  logic             is_mul;

  // Multiplier and divider hookup
  logic                 mul_start, mul_done, mul_rnd;
  logic [SB-1:0]        mul_a;
  logic [COEF_BITS-1:0] mul_b;
  logic [PW-1:0]        prod;
  logic                 div_start, div_done;
  logic [DIV_W-1:0]     div_num, div_den, sq_w;
  logic [QUO_W-1:0]     quo;

  // Product post-processing
  logic signed [WW-1:0] ps_w, pc_raw, pc_w, x_w, c2_w, pa_w, t_w, v1_w, v2_w;
  logic [SB-1:0]        pc, v2_new;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  // Select the active stage's state
  assign c1     = stage_q ? lp_i1_q : hp_i1_q;
  assign c2     = stage_q ? lp_i2_q : hp_i2_q;
  assign c1_mag = c1[SB-1] ? (~c1 + 1'b1) : c1;
  assign c1_sh  = c1_mag >> SH;
  assign u      = (c1_sh > SB'(U_MAX)) ? U_MAX : c1_sh[U_W-1:0];

  // Pick the coefficient and value for a coefficient product
  always_comb begin
    csel = CSEL_A1;
    val  = t_q;
    case (state_q)
      S_A1T:   begin csel = CSEL_A1;   val = t_q;  end
      S_A2V3:  begin csel = CSEL_A2;   val = v3_q; end
      S_A2T:   begin csel = CSEL_A2;   val = t_q;  end
      S_A3V3:  begin csel = CSEL_A3;   val = v3_q; end
      S_KV1:   begin csel = CSEL_DAMP; val = v1_q; end
      default: begin csel = CSEL_A1;   val = t_q;  end
    endcase
  end

  assign cf      = cfg_q[{stage_q, csel}];
  assign cf_mag  = cf[COEF_BITS-1] ? (~cf + 1'b1) : cf;
  assign val_mag = val[SB-1] ? (~val + 1'b1) : val;
  assign t_abs   = t_q[SB-1] ? (~t_q + 1'b1) : t_q;

  assign is_mul = (state_q inside {S_SQ, S_SAT, S_A1T, S_A2V3, S_A2T, S_A3V3, S_KV1});

  // Multiplier operands per step
  always_comb begin
    case (state_q)
      S_SQ: begin
        mul_a   = SB'(u);
        mul_b   = COEF_BITS'(u);
        mul_rnd = 1'b0;
      end
      S_SAT: begin
        mul_a   = mag_q;
        mul_b   = COEF_BITS'(r_q);
        mul_rnd = 1'b0;
      end
      default: begin
        mul_a   = val_mag;
        mul_b   = cf_mag;
        mul_rnd = 1'b1;
      end
    endcase
  end

  assign mul_start = is_mul && !op_run_q;
  assign div_start = (state_q == S_DIV) && !op_run_q;

  assign sq_w    = {{(DIV_W-SQ_W){1'b0}}, sq_q};
  assign div_num = SAT_BIAS + sq_w;
  assign div_den = SAT_BIAS + (sq_w << 3) + sq_w;

  csvf_mul #(
    .A_W(SB),
    .B_W(COEF_BITS)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .rnd_i   (mul_rnd),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  csvf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // Scale, sign and clamp the finished product
  assign ps_w   = $signed({{(WW-SB-4){1'b0}}, prod[PW-1:COEF_FRAC]});
  assign pc_raw = pneg_q ? -ps_w : ps_w;
  assign pc     = sat_sb(pc_raw);
  assign pc_w   = sx_sb(pc);

  assign x_w  = sx_sw(x_q);
  assign c2_w = sx_sb(c2);
  assign pa_w = sx_sb(pa_q);
  assign t_w  = sx_sb(t_q);
  assign v1_w = sx_sb(v1_q);
  assign v2_w = sx_sb(v2_q);

  assign v2_new = sat_sb(c2_w + pa_w + pc_w);

  // Sequence the steps of both stages
  always_comb begin
    state_d     = state_q;
    op_run_d    = op_run_q;
    stage_d     = stage_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_SQ;
          stage_d = 1'b0;
        end
      end
      S_DIV: begin
        if (!op_run_q) begin
          op_run_d = 1'b1;
        end else if (div_done) begin
          op_run_d = 1'b0;
          state_d  = S_SAT;
        end
      end
      S_SQ, S_SAT, S_A1T, S_A2V3, S_A2T, S_A3V3, S_KV1: begin
        if (!op_run_q) begin
          op_run_d = 1'b1;
        end else if (mul_done) begin
          op_run_d = 1'b0;
          case (state_q)
            S_SQ:    state_d = S_DIV;
            S_SAT:   state_d = S_A1T;
            S_A1T:   state_d = S_A2V3;
            S_A2V3:  state_d = S_A2T;
            S_A2T:   state_d = S_A3V3;
            S_A3V3:  state_d = stage_q ? S_OUT : S_KV1;
            S_KV1: begin
              state_d = S_SQ;
              stage_d = 1'b1;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_OUT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold control state, coefficients and integrators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_run_q    <= 1'b0;
      stage_q     <= 1'b0;
      out_valid_q <= 1'b0;
      hp_i1_q     <= '0;
      hp_i2_q     <= '0;
      lp_i1_q     <= '0;
      lp_i2_q     <= '0;
      cfg_q[REG_HP_A1]      <= COEF_ONE;
      cfg_q[REG_HP_A2]      <= COEF_ZERO;
      cfg_q[REG_HP_A3]      <= COEF_ZERO;
      cfg_q[REG_HP_DAMPING] <= COEF_TWO;
      cfg_q[REG_LP_A1]      <= COEF_ONE;
      cfg_q[REG_LP_A2]      <= COEF_ZERO;
      cfg_q[REG_LP_A3]      <= COEF_ZERO;
      cfg_q[REG_LP_DAMPING] <= COEF_TWO;
    end else begin
      state_q     <= state_d;
      op_run_q    <= op_run_d;
      stage_q     <= stage_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) cfg_q[cfg_idx_i] <= cfg_data_i;
      // Advance the integrators once v2 is known
      if ((state_q == S_A3V3) && op_run_q && mul_done) begin
        if (stage_q) begin
          lp_i1_q <= sat_sb((v1_w <<< 1) - t_w);
          lp_i2_q <= sat_sb((sx_sb(v2_new) <<< 1) - c2_w);
        end else begin
          hp_i1_q <= sat_sb((v1_w <<< 1) - t_w);
          hp_i2_q <= sat_sb((sx_sb(v2_new) <<< 1) - c2_w);
        end
      end
    end
  end

  // Capture operands and intermediate results
  always_ff @(posedge clk_i) begin
    if (in_acc) x_q <= sample_in_i;
    if (mul_start) pneg_q <= (state_q == S_SAT) ? neg_q : (val[SB-1] ^ cf[COEF_BITS-1]);
    if ((state_q == S_SQ) && !op_run_q) begin
      mag_q <= c1_mag;
      neg_q <= c1[SB-1];
      v3_q  <= sat_sb(x_w - c2_w);
    end
    if (div_done) r_q <= quo;
    if (op_run_q && mul_done) begin
      case (state_q)
        S_SQ:   sq_q <= prod[SQ_W-1:0];
        S_SAT:  t_q  <= pc;
        S_A1T:  pa_q <= pc;
        S_A2V3: v1_q <= sat_sb(pa_w + pc_w);
        S_A2T:  pa_q <= pc;
        S_A3V3: v2_q <= v2_new;
        S_KV1:  x_q  <= sat_sw(x_w - pc_w - v2_w);
        default: ;
      endcase
    end
    if (out_load) out_q <= sat_sw(v2_w);
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;

  // The multiplier and the divider never finish together
  a_units_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({mul_done, div_done}))
    else $error("multiplier and divider finished in the same cycle");

  // A pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !out_load)
    else $error("output register reloaded while stalled");

  // The saturator never grows the magnitude of the integrator
  a_sat_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_SAT) && op_run_q && mul_done) |=> (t_abs <= mag_q))
    else $error("saturator output exceeds its input");

endmodule

// ----- rtl/csvf_mul.sv -----
// Shift-and-add multiplier: one multiplier bit per cycle, unsigned.
`timescale 1ns / 1ps
module csvf_mul import csvf_pkg::*; #(
  parameter int A_W = STATE_BITS_DEF,
  parameter int B_W = COEF_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [A_W-1:0]     a_i,
  input  logic [B_W-1:0]     b_i,
  input  logic               rnd_i,
  output logic               done_o,
  output logic [A_W+B_W-1:0] prod_o
);

  localparam int P_W = A_W + B_W;
  localparam int C_W = $clog2(B_W + 1);

  logic           busy_q, busy_d;
  logic           done_q, done_d;
  logic [C_W-1:0] cnt_q, cnt_d;
  logic [P_W-1:0] a_q;
  logic [B_W-1:0] b_q;
  logic [P_W-1:0] acc_q;

  // Count the bits of b and flag the last one
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = C_W'(B_W);
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == C_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Add the shifted multiplicand for each set bit, LSB first
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= {{B_W{1'b0}}, a_i};
      b_q   <= b_i;
      acc_q <= rnd_i ? (P_W'(1) << RND_POS) : '0;
    end else if (busy_q) begin
      a_q   <= a_q << 1;
      b_q   <= b_q >> 1;
      acc_q <= acc_q + (b_q[0] ? a_q : '0);
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ----- rtl/csvf_div.sv -----
// Restoring divider for the saturator ratio: one quotient bit per cycle.
`timescale 1ns / 1ps
module csvf_div import csvf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] num_i,
  input  logic [DIV_W-1:0] den_i,
  output logic             done_o,
  output logic [QUO_W-1:0] quo_o
);

  localparam int C_W = $clog2(QUO_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [C_W-1:0]   cnt_q, cnt_d;
  logic [DIV_W:0]   rem_q;
  logic [DIV_W-1:0] den_q;
  logic [QUO_W-1:0] quo_q;
  logic             ge;
  logic [DIV_W:0]   rem_sub;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = C_W'(QUO_W);
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == C_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Trial subtract; the remainder stays below twice the divisor
  assign ge      = rem_q >= {1'b0, den_q};
  assign rem_sub = ge ? (rem_q - {1'b0, den_q}) : rem_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, num_i};
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= {rem_sub[DIV_W-1:0], 1'b0};
      quo_q <= {quo_q[QUO_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
